### hw/rtl/bgbu_pkg.sv
// Shared types and constants for the bloom grid blur and upsample block.
package bgbu_pkg;

    // Grid size defaults
    localparam int DEF_GRID_ROWS = 20;
    localparam int DEF_GRID_COLS = 15;

    // Item and result field widths
    localparam int CMD_W    = 2;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 4;
    localparam int COLOR_W  = 15;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W    = 8;
    localparam int KSTEP_W  = 2;
    localparam int CSTEP_W  = 3;
    localparam int STEP_W   = KSTEP_W + CSTEP_W;
    localparam int IN_DATA_W  = ROW_W + COL_W + COLOR_W;  // 24, whole bytes
    localparam int OUT_DATA_W = 16;                      // 13 bits used

    // Item commands
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLUR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_MODE = 2'd2;

    localparam logic [VAL_W-1:0] LIT_VALUE = 8'd128;

    // Controller to datapath
    typedef struct packed {
        logic       capture;      // latch the accepted item
        logic       clr_step;     // zero one memory word, advance pointer
        logic       wr_load;      // write thresholded cell
        logic       blur_init;    // start raster walk at first interior cell
        logic       blur_rd;      // issue one read of the cell or a neighbor
        logic       blur_acc;     // add returned word to the running sum
        logic       blur_acc_first;
        logic       blur_wr;      // write blurred cell, advance
        logic       rend_cap;     // latch returned corner
        logic       step_init;
        logic       step_issue;   // push one result into the interpolator
        logic [1:0] sel;          // which cell, neighbor or corner to read
        logic [1:0] cap_sel;      // which corner is returning
    } bgbu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             load_ok;
        logic             render_ok;
        logic             soft_mode;
        logic             clr_last;
        logic             blur_last;
        logic             step_ready;
        logic             step_last;
    } bgbu_status_t;

endpackage

### hw/rtl/bgbu_ram.sv
// Generic single write port, single read port RAM with registered read.
module bgbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bgbu_ctrl.sv
// Sequencer for clear, load, blur and render items.
module bgbu_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bgbu_pkg::bgbu_status_t status,
    output bgbu_pkg::bgbu_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_BLUR   = 3'd3;
    localparam logic [2:0] ST_CORNER = 3'd4;
    localparam logic [2:0] ST_STEP   = 3'd5;

    localparam logic [2:0] PH_LAST = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] phase_m1;

    assign s_tready = (state_reg == ST_IDLE);
    assign phase_m1 = phase_reg - 3'd1;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.sel     = phase_reg[1:0];
        cmd.cap_sel = phase_m1[1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                phase_next = '0;
                state_next = ST_IDLE;
                unique case (status.item_cmd)
                    bgbu_pkg::CMD_LOAD: begin
                        cmd.wr_load = status.load_ok;
                    end
                    bgbu_pkg::CMD_BLUR: begin
                        if (status.soft_mode) begin
                            cmd.blur_init = 1'b1;
                            state_next    = ST_BLUR;
                        end
                    end
                    bgbu_pkg::CMD_RENDER: begin
                        if (status.render_ok) begin
                            cmd.step_init = 1'b1;
                            state_next    = ST_CORNER;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_BLUR: begin
                // reads go out in phases 0..3, data returns in phases 1..4
                cmd.blur_rd        = (phase_reg != PH_LAST);
                cmd.blur_acc       = (phase_reg != 3'd0);
                cmd.blur_acc_first = (phase_reg == 3'd1);
                cmd.blur_wr        = (phase_reg == PH_LAST);
                if (phase_reg == PH_LAST) begin
                    phase_next = '0;
                    if (status.blur_last) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_CORNER: begin
                cmd.rend_cap = (phase_reg != 3'd0);
                if (phase_reg == PH_LAST) begin
                    phase_next = '0;
                    state_next = ST_STEP;
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_STEP: begin
                cmd.step_issue = status.step_ready;
                if (status.step_ready && status.step_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### hw/rtl/bgbu_datapath.sv
// Grid memory, config registers, blur accumulator and two-stage interpolator.
module bgbu_datapath #(
    parameter int GRID_ROWS = bgbu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = bgbu_pkg::DEF_GRID_COLS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bgbu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgbu_pkg::CFG_W-1:0]           cfg_data,
    input  logic [bgbu_pkg::CMD_W-1:0]           in_cmd,
    input  logic [bgbu_pkg::ROW_W-1:0]           in_row,
    input  logic [bgbu_pkg::COL_W-1:0]           in_col,
    input  logic [bgbu_pkg::COLOR_W-1:0]         in_color,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [bgbu_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    input  bgbu_pkg::bgbu_cmd_t                  cmd,
    output bgbu_pkg::bgbu_status_t               status
);

    localparam int RB = $clog2(GRID_ROWS);
    localparam int CB = $clog2(GRID_COLS);
    localparam int AW = RB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int VW = bgbu_pkg::VAL_W;
    localparam int ACC_W = VW + 3;

    localparam logic [RB-1:0] ROW_LAST = RB'(GRID_ROWS - 2);
    localparam logic [CB-1:0] COL_LAST = CB'(GRID_COLS - 2);
    localparam logic [RB-1:0] ROW_EDGE = RB'(GRID_ROWS - 1);
    localparam logic [CB-1:0] COL_EDGE = CB'(GRID_COLS - 1);

    // Config
    logic [VW-1:0] bias_reg, threshold_reg;
    logic          soft_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg      <= '0;
            threshold_reg <= '0;
            soft_reg      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bgbu_pkg::CFG_BIAS:      bias_reg      <= cfg_data;
                bgbu_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                bgbu_pkg::CFG_SOFT_MODE: soft_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Item latch
    logic [bgbu_pkg::CMD_W-1:0]   item_cmd_reg;
    logic [bgbu_pkg::ROW_W-1:0]   item_row_reg;
    logic [bgbu_pkg::COL_W-1:0]   item_col_reg;
    logic [bgbu_pkg::COLOR_W-1:0] item_color_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_cmd_reg   <= in_cmd;
            item_row_reg   <= in_row;
            item_col_reg   <= in_col;
            item_color_reg <= in_color;
        end
    end

    int unsigned row_ext, col_ext;
    logic [RB-1:0] ir, ir_p1;
    logic [CB-1:0] ic, ic_p1;
    logic          load_ok, render_ok;
    logic [9:0]    load_sum;
    logic [VW-1:0] load_val;

    assign row_ext   = 32'(item_row_reg);
    assign col_ext   = 32'(item_col_reg);
    assign ir        = row_ext[RB-1:0];
    assign ic        = col_ext[CB-1:0];
    assign ir_p1     = ir + RB'(1);
    assign ic_p1     = ic + CB'(1);
    assign load_ok   = (row_ext >= 1) && (row_ext <= 32'(GRID_ROWS - 2)) &&
                       (col_ext >= 1) && (col_ext <= 32'(GRID_COLS - 2));
    assign render_ok = (row_ext <= 32'(GRID_ROWS - 2)) && (col_ext <= 32'(GRID_COLS - 2));
    assign load_sum  = 10'(item_color_reg[14:10]) + 10'(item_color_reg[9:5])
                     + 10'(item_color_reg[4:0]) + 10'(bias_reg);
    assign load_val  = (load_sum > 10'(threshold_reg)) ? bgbu_pkg::LIT_VALUE : '0;

    // Clear pointer and blur walk
    logic [AW-1:0]    clr_ptr_reg;
    logic [RB-1:0]    by_reg;
    logic [CB-1:0]    bx_reg;
    logic [RB-1:0]    by_m1, by_p1;
    logic [CB-1:0]    bx_p1;
    logic [VW-1:0]    left_reg;
    logic [ACC_W-1:0] acc_reg, acc_sum;
    logic [VW-1:0]    blur_val;
    logic             blur_last;

    assign by_m1     = by_reg - RB'(1);
    assign by_p1     = by_reg + RB'(1);
    assign bx_p1     = bx_reg + CB'(1);
    assign blur_last = (by_reg == ROW_LAST) && (bx_reg == COL_LAST);

    logic [VW-1:0] rdata;
    assign acc_sum  = (cmd.blur_acc_first ? ACC_W'(left_reg) : acc_reg) + ACC_W'(rdata);
    assign blur_val = acc_sum[ACC_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
            by_reg      <= '0;
            bx_reg      <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (cmd.blur_init) begin
                by_reg <= RB'(1);
                bx_reg <= CB'(1);
            end else if (cmd.blur_wr) begin
                if (bx_reg == COL_LAST) begin
                    bx_reg <= CB'(1);
                    by_reg <= by_p1;
                end else begin
                    bx_reg <= bx_p1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.blur_acc) begin
            acc_reg <= acc_sum;
        end
        // column zero is border, so each row starts with a zero left neighbor
        if (cmd.blur_init || (cmd.blur_wr && bx_reg == COL_LAST)) begin
            left_reg <= '0;
        end else if (cmd.blur_wr) begin
            left_reg <= blur_val;
        end
    end

    // Memory ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [VW-1:0] wdata;

    always_comb begin
        we    = 1'b1;
        waddr = {by_reg, bx_reg};
        wdata = blur_val;
        priority if (cmd.clr_step) begin
            waddr = clr_ptr_reg;
            wdata = '0;
        end else if (cmd.wr_load) begin
            waddr = {ir, ic};
            wdata = load_val;
        end else if (cmd.blur_wr) begin
            waddr = {by_reg, bx_reg};
            wdata = blur_val;
        end else begin
            we = 1'b0;
        end
    end

    always_comb begin
        if (cmd.blur_rd) begin
            unique case (cmd.sel)
                2'd0:    raddr = {by_reg, bx_reg};
                2'd1:    raddr = {by_m1, bx_reg};
                2'd2:    raddr = {by_p1, bx_reg};
                default: raddr = {by_reg, bx_p1};
            endcase
        end else begin
            unique case (cmd.sel)
                2'd0:    raddr = {ir, ic};
                2'd1:    raddr = {ir, ic_p1};
                2'd2:    raddr = {ir_p1, ic};
                default: raddr = {ir_p1, ic_p1};
            endcase
        end
    end

    bgbu_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Corners
    logic [VW-1:0] corner_reg [4];

    always_ff @(posedge aclk) begin
        if (cmd.rend_cap) begin
            corner_reg[cmd.cap_sel] <= rdata;
        end
    end

    // Interpolator stage A: horizontal interpolation on both corner rows
    logic [bgbu_pkg::STEP_W-1:0] step_reg;
    logic                        sa_vld_reg, out_vld_reg;
    logic                        out_load, step_ready;
    logic [VW-1:0]               s1_reg, s2_reg;
    logic [bgbu_pkg::KSTEP_W-1:0] sa_k_reg;
    logic [bgbu_pkg::CSTEP_W-1:0] sa_c_reg;
    logic                        sa_last_reg;

    logic [3:0]         m_step;
    logic signed [4:0]  m_s;
    logic signed [8:0]  d1, d2;
    logic signed [13:0] p1, p2, s1_w, s2_w;

    assign out_load   = sa_vld_reg && (!out_vld_reg || m_tready);
    assign step_ready = !sa_vld_reg || out_load;

    assign m_step = 4'(step_reg[bgbu_pkg::CSTEP_W-1:0]) + 4'd1;
    assign m_s    = $signed({1'b0, m_step});
    assign d1     = $signed({1'b0, corner_reg[1]}) - $signed({1'b0, corner_reg[0]});
    assign d2     = $signed({1'b0, corner_reg[3]}) - $signed({1'b0, corner_reg[2]});
    assign p1     = m_s * d1;
    assign p2     = m_s * d2;
    // arithmetic shift gives floor division toward minus infinity
    assign s1_w   = $signed({6'b0, corner_reg[0]}) + (p1 >>> 3);
    assign s2_w   = $signed({6'b0, corner_reg[2]}) + (p2 >>> 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            sa_vld_reg <= 1'b0;
        end else begin
            if (cmd.step_init) begin
                step_reg <= '0;
            end else if (cmd.step_issue) begin
                step_reg <= step_reg + bgbu_pkg::STEP_W'(1);
            end
            if (cmd.step_issue) begin
                sa_vld_reg <= 1'b1;
            end else if (out_load) begin
                sa_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_issue) begin
            s1_reg      <= s1_w[VW-1:0];
            s2_reg      <= s2_w[VW-1:0];
            sa_k_reg    <= step_reg[bgbu_pkg::STEP_W-1:bgbu_pkg::CSTEP_W];
            sa_c_reg    <= step_reg[bgbu_pkg::CSTEP_W-1:0];
            sa_last_reg <= &step_reg;
        end
    end

    // Stage B: vertical interpolation, darken, output register
    logic signed [8:0]  dv;
    logic signed [3:0]  kk;
    logic signed [12:0] pv, v_w;
    logic [VW-1:0]      v, add_val;
    logic [VW-1:0]      out_add_reg;
    logic [bgbu_pkg::KSTEP_W-1:0] out_k_reg;
    logic [bgbu_pkg::CSTEP_W-1:0] out_c_reg;
    logic               out_last_reg;

    assign dv      = $signed({1'b0, s2_reg}) - $signed({1'b0, s1_reg});
    assign kk      = $signed({1'b0, sa_k_reg, 1'b0});
    assign pv      = dv * kk;
    assign v_w     = $signed({5'b0, s1_reg}) + (pv >>> 3);
    assign v       = v_w[12] ? '0 : v_w[VW-1:0];
    assign add_val = soft_reg ? v : (v >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_add_reg  <= add_val;
            out_k_reg    <= sa_k_reg;
            out_c_reg    <= sa_c_reg;
            out_last_reg <= sa_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_add_reg, out_c_reg, out_k_reg};
    assign m_tlast  = out_last_reg;

    assign status.item_cmd   = item_cmd_reg;
    assign status.load_ok    = load_ok;
    assign status.render_ok  = render_ok;
    assign status.soft_mode  = soft_reg;
    assign status.clr_last   = &clr_ptr_reg;
    assign status.blur_last  = blur_last;
    assign status.step_ready = step_ready;
    assign status.step_last  = &step_reg;

    // Checks
    logic [RB-1:0] wrow;
    logic [CB-1:0] wcol;
    assign wrow = waddr[AW-1:CB];
    assign wcol = waddr[CB-1:0];

    a_issue_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_issue |-> step_ready)
        else $error("interpolator step issued into a full stage");

    a_blur_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.blur_wr |-> (blur_val <= 8'd159))
        else $error("blurred cell exceeds five-cell average bound");

    a_interior_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_load || cmd.blur_wr) |->
            (wrow != '0 && wrow != ROW_EDGE && wcol != '0 && wcol != COL_EDGE))
        else $error("write to a border cell");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_last_reg) |-> (out_k_reg == 2'd3 && out_c_reg == 3'd7))
        else $error("last flag on a result other than the final one");

endmodule

### hw/rtl/bloom_grid_blur_upsample_unit.sv
// Top level of the bloom grid: threshold load, in-place blur, bilinear render.
//
// After reset the block zeroes its grid memory, one word a cycle over
// 2^(clog2(GRID_ROWS)+clog2(GRID_COLS)) words (512 words at 20x15), with
// s_tready low; configuration writes are taken throughout. Items are taken
// one at a time. A load of an interior cell is written in the decode state.
// A blur, done only in soft mode, walks the interior cells in raster order;
// each cell needs four reads on the single read port of the grid memory.
// A render fetches its four corners, then issues one beat per cycle, while
// m_tready stays high, through a two-stage interpolator into the output
// register, 32 beats in all; s_tready returns as soon as the last beat
// enters the interpolator.
module bloom_grid_blur_upsample_unit #(
    parameter int GRID_ROWS = bgbu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = bgbu_pkg::DEF_GRID_COLS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bgbu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgbu_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bgbu_pkg::IN_DATA_W-1:0]       s_tdata,  // grid_row, grid_col, sample_color
    input  logic [bgbu_pkg::CMD_W-1:0]           s_tuser,  // command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bgbu_pkg::OUT_DATA_W-1:0]      m_tdata,  // row_pair, column_step, add_value
    output logic                                 m_tlast
);

    bgbu_pkg::bgbu_cmd_t    cmd;
    bgbu_pkg::bgbu_status_t status;

    bgbu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bgbu_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (s_tuser),
        .in_row    (s_tdata[4:0]),
        .in_col    (s_tdata[8:5]),
        .in_color  (s_tdata[23:9]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
